### design/mmn8_pkg.sv
// Package for the min-max normalizer to 8-bit mono pixels.
// Shared widths, the command and status structs between controller and datapath.
// No dependencies.
package mmn8_pkg;

   localparam int MAX_PIXELS  = 16384;
   localparam int SAMPLE_BITS = 16;
   localparam int PIXEL_W     = 8;
   localparam int ADDR_W      = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
   localparam int CNT_W       = $clog2(MAX_PIXELS + 1);
   localparam int NUM_W       = SAMPLE_BITS + PIXEL_W;
   localparam int STEP_W      = $clog2(PIXEL_W);

   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_READ = 1'b1;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;
   typedef logic [PIXEL_W-1:0]            pixel_type;

   typedef struct packed {
      logic load;
      logic read_start;
      logic div_init;
      logic div_step;
      logic rsp_load;
   } mmn8_cmd_type;

   typedef struct packed {
      logic readable;
   } mmn8_status_type;

endpackage

### design/mmn8_if.sv
// Handshake channels of the normalizer: request and response items.
// Depends on mmn8_pkg.
interface mmn8_req_if;
   import mmn8_pkg::*;
   logic       valid;
   logic       ready;
   logic       kind;
   sample_type sample;
   logic       frame_end;

   modport source (output valid, kind, sample, frame_end, input ready);
   modport sink   (input valid, kind, sample, frame_end, output ready);
endinterface

interface mmn8_rsp_if;
   import mmn8_pkg::*;
   logic      valid;
   logic      ready;
   pixel_type pixel;
   logic      last_pixel;
   logic      empty_res;
   logic      overflow;

   modport source (output valid, pixel, last_pixel, empty_res, overflow, input ready);
   modport sink   (input valid, pixel, last_pixel, empty_res, overflow, output ready);
endinterface

### design/mmn8_ctrl.sv
// Controller of the normalizer: sequences load, fetch, serial divide and output.
// Depends on mmn8_pkg.
module mmn8_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_kind,
   output logic                      req_ready,
   input  logic                      rsp_ready,
   output logic                      rsp_valid,
   input  mmn8_pkg::mmn8_status_type status,
   output mmn8_pkg::mmn8_cmd_type    cmd
);
   import mmn8_pkg::*;

   typedef enum logic [1:0] {ST_IDLE, ST_FETCH, ST_DIVIDE, ST_OUTPUT} state_type;

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              accept;
   logic              out_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd        = '0;
      state_in   = state_ff;
      step_in    = step_ff;
      cmd.load       = accept && (req_kind == KIND_LOAD);
      cmd.read_start = accept && (req_kind == KIND_READ);
      case (state_ff)
         ST_IDLE: begin
            if (cmd.read_start) begin
               state_in = status.readable ? ST_FETCH : ST_OUTPUT;
            end
         end
         ST_FETCH: begin
            cmd.div_init = 1'b1;
            step_in      = '0;
            state_in     = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff + 1'b1;
            if (step_ff == STEP_W'(PIXEL_W - 1)) begin
               state_in = ST_OUTPUT;
            end
         end
         ST_OUTPUT: begin
            if (out_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rsp_valid_in = cmd.rsp_load || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

### design/mmn8_datapath.sv
// Datapath of the normalizer: frame store, running min/max, read pointer,
// restoring divider and the output register. Depends on mmn8_pkg.
module mmn8_datapath (
   input  logic                      clock,
   input  logic                      reset,
   input  mmn8_pkg::mmn8_cmd_type    cmd,
   output mmn8_pkg::mmn8_status_type status,
   input  mmn8_pkg::sample_type      req_sample,
   input  logic                      req_frame_end,
   output mmn8_pkg::pixel_type       rsp_pixel,
   output logic                      rsp_last_pixel,
   output logic                      rsp_empty_res,
   output logic                      rsp_overflow
);
   import mmn8_pkg::*;

   sample_type mem [MAX_PIXELS];

   sample_type       min_ff, max_ff;
   logic [CNT_W-1:0] count_ff, rp_ff;
   logic             closed_ff, ovf_ff;

   sample_type       rd_data_ff;
   logic [NUM_W-1:0] num_ff, div_ff;
   pixel_type        q_ff;
   logic             zero_ff, res_last_ff, res_empty_ff, res_ovf_ff;

   pixel_type        out_pixel_ff;
   logic             out_last_ff, out_empty_ff, out_ovf_ff;

   logic [CNT_W-1:0]       base_count, rd_addr, rd_addr_inc;
   logic                   base_ovf, has_room, readable, is_last;
   logic [SAMPLE_BITS:0]   diff_wide, range_wide;
   logic [SAMPLE_BITS-1:0] diff, range_v;
   logic [NUM_W-1:0]       num_init, num_sub;
   logic                   ge;

   assign base_count  = closed_ff ? '0 : count_ff;
   assign base_ovf    = closed_ff ? 1'b0 : ovf_ff;
   assign has_room    = base_count < CNT_W'(MAX_PIXELS);
   assign readable    = closed_ff && (count_ff != '0);
   assign status.readable = readable;

   assign rd_addr     = (rp_ff >= count_ff) ? '0 : rp_ff;
   assign rd_addr_inc = rd_addr + 1'b1;
   assign is_last     = (rd_addr_inc == count_ff);

   assign diff_wide  = {rd_data_ff[SAMPLE_BITS-1], rd_data_ff} - {min_ff[SAMPLE_BITS-1], min_ff};
   assign range_wide = {max_ff[SAMPLE_BITS-1], max_ff} - {min_ff[SAMPLE_BITS-1], min_ff};
   assign diff       = diff_wide[SAMPLE_BITS-1:0];
   assign range_v    = range_wide[SAMPLE_BITS-1:0];
   // 255*d - 1
   assign num_init   = {diff, {PIXEL_W{1'b0}}} - NUM_W'(diff) - NUM_W'(1);

   assign ge      = num_ff >= div_ff;
   assign num_sub = num_ff - div_ff;

   always_ff @(posedge clock) begin
      if (cmd.load && has_room) begin
         mem[base_count[ADDR_W-1:0]] <= req_sample;
      end
      if (cmd.read_start) begin
         rd_data_ff <= mem[rd_addr[ADDR_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff    <= '0;
         max_ff    <= '0;
         count_ff  <= '0;
         rp_ff     <= '0;
         closed_ff <= 1'b0;
         ovf_ff    <= 1'b0;
      end else begin
         if (cmd.load) begin
            if (has_room) begin
               if (base_count == '0) begin
                  min_ff <= req_sample;
                  max_ff <= req_sample;
               end else begin
                  if (req_sample < min_ff) begin
                     min_ff <= req_sample;
                  end
                  if (req_sample > max_ff) begin
                     max_ff <= req_sample;
                  end
               end
               count_ff <= base_count + 1'b1;
            end else begin
               count_ff <= base_count;
            end
            ovf_ff    <= base_ovf || !has_room;
            closed_ff <= req_frame_end;
            if (closed_ff || req_frame_end) begin
               rp_ff <= '0;
            end
         end else if (cmd.read_start && readable) begin
            rp_ff <= is_last ? '0 : rd_addr_inc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.read_start) begin
         zero_ff      <= 1'b1;
         res_last_ff  <= readable && is_last;
         res_empty_ff <= !readable;
         res_ovf_ff   <= ovf_ff;
      end
      if (cmd.div_init) begin
         zero_ff <= (diff == '0) || (range_v == '0);
         num_ff  <= num_init;
         div_ff  <= NUM_W'({range_v, {(PIXEL_W-1){1'b0}}});
      end
      if (cmd.div_step) begin
         if (ge) begin
            num_ff <= num_sub;
         end
         q_ff   <= {q_ff[PIXEL_W-2:0], ge};
         div_ff <= div_ff >> 1;
      end
      if (cmd.rsp_load) begin
         out_pixel_ff <= zero_ff ? '0 : q_ff;
         out_last_ff  <= res_last_ff;
         out_empty_ff <= res_empty_ff;
         out_ovf_ff   <= res_ovf_ff;
      end
   end

   assign rsp_pixel      = out_pixel_ff;
   assign rsp_last_pixel = out_last_ff;
   assign rsp_empty_res  = out_empty_ff;
   assign rsp_overflow   = out_ovf_ff;

endmodule

### design/min_max_normalize_to_mono8_top.sv
// Top level of the min-max normalizer to 8-bit mono pixels.
// Joins mmn8_ctrl and mmn8_datapath; depends on mmn8_pkg and mmn8_if.
//
//   channel  dir  payload                                   handshake
//   req_ch   in   kind, sample[15:0], frame_end             valid/ready
//   rsp_ch   out  pixel[7:0], last_pixel, empty_res, overflow valid/ready
//
// A load item is stored when accepted. A readout runs store read, divider
// setup, 8 restoring divide steps (one quotient bit per cycle), output load.
// An empty readout skips the divider. Items are handled one at a time.
// Synchronous active-high reset; the frame store is not cleared.
// A stalled response holds in the output register; loads are still taken.
module min_max_normalize_to_mono8_top (
   input logic        clock,
   input logic        reset,
   mmn8_req_if.sink   req_ch,
   mmn8_rsp_if.source rsp_ch
);
   import mmn8_pkg::*;

   mmn8_cmd_type    cmd;
   mmn8_status_type status;

   mmn8_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_kind  (req_ch.kind),
      .req_ready (req_ch.ready),
      .rsp_ready (rsp_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .status    (status),
      .cmd       (cmd)
   );

   mmn8_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_sample     (req_ch.sample),
      .req_frame_end  (req_ch.frame_end),
      .rsp_pixel      (rsp_ch.pixel),
      .rsp_last_pixel (rsp_ch.last_pixel),
      .rsp_empty_res  (rsp_ch.empty_res),
      .rsp_overflow   (rsp_ch.overflow)
   );

endmodule
